[hw/rtl/abl_pkg.sv]
// shared types and constants for the address blocklist
// no dependencies; imported by the controller, datapath and top level
`default_nettype none

package abl_pkg;

    // field widths of one request
    localparam int CMD_W   = 2;
    localparam int IP_W    = 32;
    localparam int PORT_W  = 16;
    localparam int DUR_W   = 20;
    localparam int TIME_W  = 32;
    localparam int KEY_W   = IP_W + PORT_W;
    localparam int EXP_W   = 33;
    localparam int ENTRY_W = KEY_W + EXP_W;

    // request codes
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, rewind scan
        logic scan_rd;   // read entry at scan index, advance
        logic commit;    // apply table update, load result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic rd_last;   // scan index is at the last entry
        logic out_free;  // result register can take a new result
    } t_dp_sts;

endpackage

`default_nettype wire

[hw/rtl/abl_controller.sv]
// sequencer for the address blocklist: accept, scan, commit
// depends on abl_pkg
`default_nettype none

module abl_controller
    import abl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.rd_last) begin
                    n_state = S_DRAIN;
                end
            end
            // last read data is evaluated here
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_commit_needs_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_sts.out_free)
        else $error("commit while result register busy");
    a_scan_follows_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.scan_rd)
        else $error("scan did not start after load");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.scan_rd || o_cmd.commit) |-> !o_in_ready)
        else $error("ready while a request is in work");
`endif

endmodule

`default_nettype wire

[hw/rtl/abl_datapath.sv]
// entry table, scan compare, table update and result register
// depends on abl_pkg; driven by abl_controller
`default_nettype none

module abl_datapath
    import abl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    input  wire logic [CMD_W-1:0]  i_cmd_code,
    input  wire logic [IP_W-1:0]   i_ip_address,
    input  wire logic [PORT_W-1:0] i_port_number,
    input  wire logic [DUR_W-1:0]  i_duration_seconds,
    input  wire logic [TIME_W-1:0] i_now_seconds,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_throttled,
    output logic                   o_table_full
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // captured request
    logic [CMD_W-1:0]  r_op;
    logic [KEY_W-1:0]  r_key;
    logic [DUR_W-1:0]  r_dur;
    logic [TIME_W-1:0] r_now;

    // table: valid bits in flops, address and expiry in memory
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [ENTRY_W-1:0]       r_mem [TABLE_ENTRIES];
    logic [ENTRY_W-1:0]       r_rd_data;

    // scan state
    logic [IDX_W-1:0] r_rd_idx;
    logic [IDX_W-1:0] r_ev_idx;
    logic             r_rd_vld;
    logic             r_hit;
    logic             r_found;
    logic [IDX_W-1:0] r_found_idx;
    logic             r_free_seen;
    logic [IDX_W-1:0] r_free_idx;

    logic r_out_vld;
    logic r_throttled;
    logic r_table_full;

    logic              ev_valid;
    logic [KEY_W-1:0]  ev_key;
    logic [EXP_W-1:0]  ev_exp;
    logic              ev_match;
    logic              ev_stale;
    logic              add_ok;
    logic [IDX_W-1:0]  wr_idx;
    logic              mem_we;
    logic [EXP_W-1:0]  wr_expiry;

    assign ev_valid = r_valid[r_ev_idx];
    assign ev_key   = r_rd_data[ENTRY_W-1 -: KEY_W];
    assign ev_exp   = r_rd_data[EXP_W-1:0];
    assign ev_match = ev_valid && (ev_key == r_key);
    assign ev_stale = ev_valid && (ev_exp < {1'b0, r_now});

    // refresh an existing entry, else take the lowest free one
    assign add_ok    = r_found || r_free_seen;
    assign wr_idx    = r_found ? r_found_idx : r_free_idx;
    assign mem_we    = i_cmd.commit && (r_op == CMD_ADD) && add_ok;
    assign wr_expiry = {1'b0, r_now} + {{(EXP_W - DUR_W){1'b0}}, r_dur};

    assign o_sts.rd_last  = (r_rd_idx == LAST_IDX);
    assign o_sts.out_free = !r_out_vld || i_out_ready;

    assign o_out_valid  = r_out_vld;
    assign o_throttled  = r_throttled;
    assign o_table_full = r_table_full;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_cmd_code;
            r_key <= {i_ip_address, i_port_number};
            r_dur <= i_duration_seconds;
            r_now <= i_now_seconds;
        end
        if (i_cmd.scan_rd) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
        if (mem_we) begin
            r_mem[wr_idx] <= {r_key, wr_expiry};
        end
        r_ev_idx <= r_rd_idx;
        if (i_cmd.commit) begin
            r_throttled  <= (r_op == CMD_QUERY) && r_hit;
            r_table_full <= (r_op == CMD_ADD) && !add_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_rd_idx    <= '0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_found     <= 1'b0;
            r_found_idx <= '0;
            r_free_seen <= 1'b0;
            r_free_idx  <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.load) begin
                r_rd_idx    <= '0;
                r_hit       <= 1'b0;
                r_found     <= 1'b0;
                r_free_seen <= 1'b0;
            end else if (i_cmd.scan_rd) begin
                r_rd_idx <= (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + 1'b1;
            end

            // one entry evaluated per cycle, in the cycle after its read
            if (r_rd_vld) begin
                if (r_op == CMD_QUERY) begin
                    if (ev_stale) begin
                        r_valid[r_ev_idx] <= 1'b0;
                    end else if (ev_match) begin
                        r_hit <= 1'b1;
                    end
                end
                if (ev_match && !r_found) begin
                    r_found     <= 1'b1;
                    r_found_idx <= r_ev_idx;
                end
                if (!ev_valid && !r_free_seen) begin
                    r_free_seen <= 1'b1;
                    r_free_idx  <= r_ev_idx;
                end
            end

            if (i_cmd.commit) begin
                if ((r_op == CMD_ADD) && add_ok) begin
                    r_valid[wr_idx] <= 1'b1;
                end
                if ((r_op == CMD_DELETE) && r_found) begin
                    r_valid[r_found_idx] <= 1'b0;
                end
            end

            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_add_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_valid[$past(wr_idx)])
        else $error("added entry not marked valid");
    a_no_eval_at_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> !i_cmd.commit && !i_cmd.load)
        else $error("commit or load during scan evaluation");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |=> r_out_vld)
        else $error("result dropped before it was taken");
    a_full_only_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_op != CMD_ADD)) |=> !r_table_full)
        else $error("table full flagged for a non-add request");
`endif

endmodule

`default_nettype wire

[hw/rtl/address_blocklist_with_expiry.sv]
// Blocklist of sender addresses (IPv4 address and UDP port) with per-entry
// expiry in seconds. Each request on the input stream carries a command in
// tuser: query (purges entries whose expiry is before now, then reports
// whether the sender is listed), add or refresh (expiry = now + duration,
// dropped with table_full when no entry matches and none is free), or
// delete. Every request gives exactly one result. A request is worked on
// alone: the controller scans the entry memory one entry per cycle, then
// evaluates the last entry and commits once the result register is free;
// the next request is taken only after the commit. The result sits in an
// output register, so a new request is accepted while a result waits.
// No clearing pass is needed after reset.
// depends on abl_pkg, abl_controller, abl_datapath
`default_nettype none

module address_blocklist_with_expiry
    import abl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // ip_address[31:0], port_number[47:32], duration_seconds[67:48],
    // now_seconds[99:68], zero[103:100]
    input  wire logic [103:0] s_axis_tdata,
    // cmd[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // throttled[0], table_full[1], zero[7:2]
    output logic [7:0]        m_axis_tdata
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    throttled;
    logic    table_full;

    abl_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (dp_cmd),
        .i_sts      (dp_sts)
    );

    abl_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .o_sts              (dp_sts),
        .i_cmd_code         (s_axis_tuser),
        .i_ip_address       (s_axis_tdata[31:0]),
        .i_port_number      (s_axis_tdata[47:32]),
        .i_duration_seconds (s_axis_tdata[67:48]),
        .i_now_seconds      (s_axis_tdata[99:68]),
        .o_out_valid        (m_axis_tvalid),
        .i_out_ready        (m_axis_tready),
        .o_throttled        (throttled),
        .o_table_full       (table_full)
    );

    assign m_axis_tdata = {6'b0, table_full, throttled};

endmodule

`default_nettype wire
